### sv/bvtc_pkg.sv
package bvtc_pkg;

    localparam int VRAM_DEPTH          = 2048;
    localparam int CARD_ROM_DEPTH_DFLT = 1024;
    localparam int GLYPH_ROM_DEPTH     = 4096;

    localparam int VRAM_AW  = $clog2(VRAM_DEPTH);
    localparam int GLYPH_AW = $clog2(GLYPH_ROM_DEPTH);

    localparam int CMD_W      = 4;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 24;

    localparam logic [7:0]  IDLE_BYTE         = 8'hFF;
    localparam logic [10:0] IO_CRTC_ADDR      = 11'd0;
    localparam logic [10:0] IO_CRTC_DATA      = 11'd1;
    localparam logic [1:0]  WINDOW_TOP_BITS   = 2'b10;
    localparam int          CURSOR_BLINK_BIT  = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_IO_READ     = 4'd0,
        CMD_IO_WRITE    = 4'd1,
        CMD_SLOT_READ   = 4'd2,
        CMD_WIN_READ    = 4'd3,
        CMD_WIN_WRITE   = 4'd4,
        CMD_VSYNC       = 4'd5,
        CMD_RENDER      = 4'd6,
        CMD_LOAD_CARD   = 4'd7,
        CMD_LOAD_GLYPH  = 4'd8
    } cmd_t;

    typedef enum logic [1:0] {
        CRTC_NONE    = 2'd0,
        CRTC_ADDR_WR = 2'd1,
        CRTC_REG_WR  = 2'd2,
        CRTC_REG_RD  = 2'd3
    } crtc_op_t;

    typedef enum logic [1:0] {
        RD_IDLE = 2'd0,
        RD_CARD = 2'd1,
        RD_VRAM = 2'd2
    } rd_src_t;

    typedef struct packed {
        rd_src_t              rd_src;
        crtc_op_t             op;
        logic [7:0]           cd;
        logic                 render;
        logic                 cursor_on;
        logic                 glyph_load;
        logic [3:0]           row;
        logic [7:0]           load_data;
        logic [GLYPH_AW-1:0]  load_addr;
    } stage1_t;

    typedef struct packed {
        logic [7:0] rd;
        crtc_op_t   op;
        logic [7:0] cd;
        logic       render;
        logic       cursor_on;
    } stage2_t;

    typedef struct packed {
        logic [7:0] read_data;
        crtc_op_t   crtc_op;
        logic [7:0] crtc_data;
        logic [7:0] pixels;
    } result_t;

endpackage

### sv/bvtc_ram.sv
module bvtc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

### sv/banked_vram_text_card_core.sv
// Channel   Direction  Transaction
// s_axis    in         one bus access, vsync, render or ROM load
// m_axis    out        one result: read byte, CRTC forward, pixel row
//
// One transaction is accepted per cycle unless the skid entry is full or the
// RAM is being cleared. Each result is registered after the video RAM read, the
// dependent glyph ROM read and in the output stage. After reset the video RAM is
// cleared one entry per cycle, so the input is stalled until all 2048 are clear.
// A two-entry output stage keeps the input open while one result waits.
module banked_vram_text_card_core #(
    parameter int CARD_ROM_DEPTH = bvtc_pkg::CARD_ROM_DEPTH_DFLT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // offset, data, row_address, char_address, is_cursor, load_address, zero pad
    input  logic [bvtc_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // cmd
    input  logic [bvtc_pkg::CMD_W-1:0]     s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // read_data, crtc_data, pixels
    output logic [bvtc_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // crtc_op
    output logic [1:0]                     m_axis_tuser
);

    localparam int CARD_AW = $clog2(CARD_ROM_DEPTH);
    localparam logic [11:0] CARD_D1 = 12'(CARD_ROM_DEPTH);
    localparam logic [11:0] CARD_D2 = 12'(2 * CARD_ROM_DEPTH);
    localparam logic [11:0] CARD_D3 = 12'(3 * CARD_ROM_DEPTH);

    logic [10:0]                 in_offset;
    logic [7:0]                  in_data;
    logic [3:0]                  in_row;
    logic [10:0]                 in_char;
    logic                        in_cursor;
    logic [11:0]                 in_load;
    bvtc_pkg::cmd_t              in_cmd;

    logic                        accept;
    logic                        adv;

    logic                        clearing_reg;
    logic [bvtc_pkg::VRAM_AW-1:0] clr_addr_reg;

    logic [1:0]                  page_base_reg;
    logic [1:0]                  page_base_next;
    logic [7:0]                  frame_count_reg;
    logic [7:0]                  frame_count_next;

    logic                        s1_valid_reg;
    bvtc_pkg::stage1_t           s1_reg;
    bvtc_pkg::stage1_t           s1_next;
    logic                        s2_valid_reg;
    bvtc_pkg::stage2_t           s2_reg;
    bvtc_pkg::stage2_t           s2_next;

    logic                        out_valid_reg;
    bvtc_pkg::result_t           out_reg;
    logic                        skid_valid_reg;
    bvtc_pkg::result_t           skid_reg;
    bvtc_pkg::result_t           result;

    logic                        vram_en;
    logic                        vram_we;
    logic [bvtc_pkg::VRAM_AW-1:0] vram_addr;
    logic [7:0]                  vram_wdata;
    logic [7:0]                  vram_q;
    logic                        item_vram_en;
    logic                        item_vram_we;
    logic [bvtc_pkg::VRAM_AW-1:0] item_vram_addr;

    logic                        card_en;
    logic                        card_we;
    logic [CARD_AW-1:0]          card_addr;
    logic [7:0]                  card_q;
    logic [11:0]                 rom_off;
    logic [11:0]                 rom_idx;

    logic                        glyph_en;
    logic [bvtc_pkg::GLYPH_AW-1:0] glyph_addr;
    logic [7:0]                  glyph_q;

    assign in_offset = s_axis_tdata[10:0];
    assign in_data   = s_axis_tdata[18:11];
    assign in_row    = s_axis_tdata[22:19];
    assign in_char   = s_axis_tdata[33:23];
    assign in_cursor = s_axis_tdata[34];
    assign in_load   = s_axis_tdata[46:35];
    assign in_cmd    = bvtc_pkg::cmd_t'(s_axis_tuser);

    assign adv           = !skid_valid_reg;
    assign s_axis_tready = !skid_valid_reg && !clearing_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        if (in_cmd == bvtc_pkg::CMD_SLOT_READ)
        begin
            rom_off = {4'd0, in_offset[7:0]};
        end
        else
        begin
            rom_off = {1'b0, in_offset};
        end
        if (rom_off >= CARD_D3)
        begin
            rom_idx = rom_off - CARD_D3;
        end
        else if (rom_off >= CARD_D2)
        begin
            rom_idx = rom_off - CARD_D2;
        end
        else if (rom_off >= CARD_D1)
        begin
            rom_idx = rom_off - CARD_D1;
        end
        else
        begin
            rom_idx = rom_off;
        end
    end

    always_comb
    begin
        page_base_next   = page_base_reg;
        frame_count_next = frame_count_reg;
        item_vram_en     = 1'b0;
        item_vram_we     = 1'b0;
        item_vram_addr   = {page_base_reg, in_offset[8:0]};
        card_en          = 1'b0;
        card_we          = 1'b0;
        card_addr        = rom_idx[CARD_AW-1:0];
        s1_next          = '0;
        s1_next.rd_src    = bvtc_pkg::RD_IDLE;
        s1_next.op        = bvtc_pkg::CRTC_NONE;
        s1_next.row       = in_row;
        s1_next.load_data = in_data;
        s1_next.load_addr = in_load;

        unique case (in_cmd)
            bvtc_pkg::CMD_IO_READ:
            begin
                page_base_next = in_offset[3:2];
                if (in_offset == bvtc_pkg::IO_CRTC_DATA)
                begin
                    s1_next.op = bvtc_pkg::CRTC_REG_RD;
                end
            end
            bvtc_pkg::CMD_IO_WRITE:
            begin
                page_base_next = in_offset[3:2];
                if (in_offset == bvtc_pkg::IO_CRTC_ADDR)
                begin
                    s1_next.op = bvtc_pkg::CRTC_ADDR_WR;
                    s1_next.cd = in_data;
                end
                else if (in_offset == bvtc_pkg::IO_CRTC_DATA)
                begin
                    s1_next.op = bvtc_pkg::CRTC_REG_WR;
                    s1_next.cd = in_data;
                end
            end
            bvtc_pkg::CMD_SLOT_READ:
            begin
                card_en        = 1'b1;
                s1_next.rd_src = bvtc_pkg::RD_CARD;
            end
            bvtc_pkg::CMD_WIN_READ:
            begin
                if (!in_offset[10])
                begin
                    card_en        = 1'b1;
                    s1_next.rd_src = bvtc_pkg::RD_CARD;
                end
                else if (in_offset[10:9] == bvtc_pkg::WINDOW_TOP_BITS)
                begin
                    item_vram_en   = 1'b1;
                    s1_next.rd_src = bvtc_pkg::RD_VRAM;
                end
            end
            bvtc_pkg::CMD_WIN_WRITE:
            begin
                if (in_offset[10:9] == bvtc_pkg::WINDOW_TOP_BITS)
                begin
                    item_vram_en = 1'b1;
                    item_vram_we = 1'b1;
                end
            end
            bvtc_pkg::CMD_VSYNC:
            begin
                frame_count_next = frame_count_reg + 8'd1;
            end
            bvtc_pkg::CMD_RENDER:
            begin
                item_vram_en      = 1'b1;
                item_vram_addr    = in_char;
                s1_next.render    = 1'b1;
                s1_next.cursor_on = in_cursor && frame_count_reg[bvtc_pkg::CURSOR_BLINK_BIT];
            end
            bvtc_pkg::CMD_LOAD_CARD:
            begin
                if (in_load < CARD_D1)
                begin
                    card_en   = 1'b1;
                    card_we   = 1'b1;
                    card_addr = in_load[CARD_AW-1:0];
                end
            end
            bvtc_pkg::CMD_LOAD_GLYPH:
            begin
                s1_next.glyph_load = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        if (clearing_reg)
        begin
            vram_en    = 1'b1;
            vram_we    = 1'b1;
            vram_addr  = clr_addr_reg;
            vram_wdata = 8'd0;
        end
        else
        begin
            vram_en    = accept && item_vram_en;
            vram_we    = item_vram_we;
            vram_addr  = item_vram_addr;
            vram_wdata = in_data;
        end
    end

    bvtc_ram #(
        .WIDTH (8),
        .DEPTH (bvtc_pkg::VRAM_DEPTH)
    ) u_vram (
        .clk   (clk),
        .en    (vram_en),
        .we    (vram_we),
        .addr  (vram_addr),
        .wdata (vram_wdata),
        .rdata (vram_q)
    );

    bvtc_ram #(
        .WIDTH (8),
        .DEPTH (CARD_ROM_DEPTH)
    ) u_card_rom (
        .clk   (clk),
        .en    (accept && card_en),
        .we    (card_we),
        .addr  (card_addr),
        .wdata (in_data),
        .rdata (card_q)
    );

    always_comb
    begin
        s2_next           = '0;
        s2_next.op        = s1_reg.op;
        s2_next.cd        = s1_reg.cd;
        s2_next.render    = s1_reg.render;
        s2_next.cursor_on = s1_reg.cursor_on;
        case (s1_reg.rd_src)
            bvtc_pkg::RD_CARD: s2_next.rd = card_q;
            bvtc_pkg::RD_VRAM: s2_next.rd = vram_q;
            default:           s2_next.rd = bvtc_pkg::IDLE_BYTE;
        endcase
        if (s1_reg.glyph_load)
        begin
            glyph_addr = s1_reg.load_addr;
        end
        else
        begin
            glyph_addr = {vram_q, s1_reg.row};
        end
        glyph_en = adv && s1_valid_reg && (s1_reg.render || s1_reg.glyph_load);
    end

    bvtc_ram #(
        .WIDTH (8),
        .DEPTH (bvtc_pkg::GLYPH_ROM_DEPTH)
    ) u_glyph_rom (
        .clk   (clk),
        .en    (glyph_en),
        .we    (s1_reg.glyph_load),
        .addr  (glyph_addr),
        .wdata (s1_reg.load_data),
        .rdata (glyph_q)
    );

    always_comb
    begin
        result.read_data = s2_reg.rd;
        result.crtc_op   = s2_reg.op;
        result.crtc_data = s2_reg.cd;
        if (!s2_reg.render)
        begin
            result.pixels = 8'd0;
        end
        else if (s2_reg.cursor_on)
        begin
            result.pixels = 8'hFF;
        end
        else
        begin
            result.pixels = glyph_q;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg    <= 1'b1;
            clr_addr_reg    <= '0;
            page_base_reg   <= '0;
            frame_count_reg <= '0;
            s1_valid_reg    <= 1'b0;
            s2_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            skid_valid_reg  <= 1'b0;
        end
        else
        begin
            if (clearing_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (&clr_addr_reg)
                begin
                    clearing_reg <= 1'b0;
                end
            end
            if (accept)
            begin
                page_base_reg   <= page_base_next;
                frame_count_reg <= frame_count_next;
            end
            if (adv)
            begin
                s1_valid_reg <= accept;
                s2_valid_reg <= s1_valid_reg;
            end
            if (m_axis_tready || !out_valid_reg)
            begin
                if (skid_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= adv && s2_valid_reg;
                end
            end
            else if (adv && s2_valid_reg)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (accept)
            begin
                s1_reg <= s1_next;
            end
            if (s1_valid_reg)
            begin
                s2_reg <= s2_next;
            end
        end
        if (m_axis_tready || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (adv && s2_valid_reg)
            begin
                out_reg <= result;
            end
        end
        else if (adv && s2_valid_reg)
        begin
            skid_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_reg.pixels, out_reg.crtc_data, out_reg.read_data};
    assign m_axis_tuser  = out_reg.crtc_op;

endmodule

### dv/bvtc_checker.sv
`timescale 1ns / 1ps

module bvtc_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [bvtc_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [bvtc_pkg::CMD_W-1:0]     s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [bvtc_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic [1:0]                     m_tuser,
    output int                             errors,
    output int                             pending
);
    import bvtc_pkg::*;

    localparam int          CARD_DEPTH   = CARD_ROM_DEPTH_DFLT;
    localparam logic [10:0] WINDOW_BASE  = 11'h400;
    localparam logic [10:0] WINDOW_LIMIT = 11'h600;
    localparam int          MAX_REPORTS  = 10;

    logic [1:0] page_sel;
    logic [7:0] frame_count;
    logic [7:0] video_ram [VRAM_DEPTH];
    logic [7:0] card_rom  [CARD_DEPTH];
    logic [7:0] glyph_rom [GLYPH_ROM_DEPTH];

    result_t pending_results[$];
    result_t got;
    result_t want;

    function automatic result_t card_step(input logic [CMD_W-1:0] cmd,
                                          input logic [S_TDATA_W-1:0] td);
        logic [10:0] off;
        logic [7:0]  din;
        logic [3:0]  row;
        logic [10:0] caddr;
        logic        cursor;
        logic [11:0] laddr;
        logic [7:0]  chr;
        result_t     r;
        off    = td[10:0];
        din    = td[18:11];
        row    = td[22:19];
        caddr  = td[33:23];
        cursor = td[34];
        laddr  = td[46:35];
        r.read_data = IDLE_BYTE;
        r.crtc_op   = CRTC_NONE;
        r.crtc_data = 8'h00;
        r.pixels    = 8'h00;
        case (cmd)
            CMD_IO_READ:
            begin
                page_sel = off[3:2];
                if (off == IO_CRTC_DATA)
                    r.crtc_op = CRTC_REG_RD;
            end
            CMD_IO_WRITE:
            begin
                if (off == IO_CRTC_ADDR)
                begin
                    r.crtc_op   = CRTC_ADDR_WR;
                    r.crtc_data = din;
                end
                else if (off == IO_CRTC_DATA)
                begin
                    r.crtc_op   = CRTC_REG_WR;
                    r.crtc_data = din;
                end
                page_sel = off[3:2];
            end
            CMD_SLOT_READ:
                r.read_data = card_rom[int'(off[7:0]) % CARD_DEPTH];
            CMD_WIN_READ:
            begin
                if (off < WINDOW_BASE)
                    r.read_data = card_rom[int'(off) % CARD_DEPTH];
                else if (off < WINDOW_LIMIT)
                    r.read_data = video_ram[{page_sel, off[8:0]}];
            end
            CMD_WIN_WRITE:
            begin
                if (off >= WINDOW_BASE && off < WINDOW_LIMIT)
                    video_ram[{page_sel, off[8:0]}] = din;
            end
            CMD_VSYNC:
                frame_count = frame_count + 8'd1;
            CMD_RENDER:
            begin
                chr      = video_ram[caddr];
                r.pixels = glyph_rom[{chr, row}];
                if (cursor && frame_count[CURSOR_BLINK_BIT])
                    r.pixels = 8'hFF;
            end
            CMD_LOAD_CARD:
            begin
                if (int'(laddr) < CARD_DEPTH)
                    card_rom[int'(laddr)] = din;
            end
            CMD_LOAD_GLYPH:
                glyph_rom[laddr] = din;
            default:
            begin
            end
        endcase
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            page_sel    = 2'd0;
            frame_count = 8'd0;
            foreach (video_ram[i]) video_ram[i] = 8'h00;
            foreach (card_rom[i]) card_rom[i] = 8'h00;
            foreach (glyph_rom[i]) glyph_rom[i] = 8'h00;
            pending_results.delete();
            pending = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.read_data = m_tdata[7:0];
                got.crtc_data = m_tdata[15:8];
                got.pixels    = m_tdata[23:16];
                got.crtc_op   = crtc_op_t'(m_tuser);
                if (pending_results.size() == 0)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: result with no transaction pending: %s",
                                 $realtime, "");
                    if (errors <= MAX_REPORTS)
                        $display("    rd %h op %0d cd %h pix %h",
                                 got.read_data, got.crtc_op, got.crtc_data, got.pixels);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got.read_data !== want.read_data || got.crtc_op !== want.crtc_op ||
                        got.crtc_data !== want.crtc_data || got.pixels !== want.pixels)
                    begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display("%0t: expected rd %h op %0d cd %h pix %h,",
                                     $realtime, want.read_data, want.crtc_op,
                                     want.crtc_data, want.pixels);
                        if (errors <= MAX_REPORTS)
                            $display("    got rd %h op %0d cd %h pix %h",
                                     got.read_data, got.crtc_op, got.crtc_data,
                                     got.pixels);
                    end
                end
            end
            if (s_tvalid && s_tready)
                pending_results.push_back(card_step(s_tuser, s_tdata));
            pending = pending_results.size();
        end
    end

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import bvtc_pkg::*;

    localparam int FIRST_UNUSED_CMD = 9;
    localparam int LAST_CMD_CODE    = 15;
    localparam int RANDOM_ITEMS     = 270;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int ROM_EDGE_ENTRIES = 64;
    localparam int CARD_TOP_BASE    = CARD_ROM_DEPTH_DFLT - ROM_EDGE_ENTRIES;
    localparam int GLYPH_TOP_BASE   = GLYPH_ROM_DEPTH - ROM_EDGE_ENTRIES;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [CMD_W-1:0]     s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [1:0]           m_tuser;
    int                   errors;
    int                   pending;

    logic gaps_on;
    logic hold_request;
    int   burst_left;

    banked_vram_text_card_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser)
    );

    bvtc_checker u_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .errors   (errors),
        .pending  (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #500_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin : sink
        int  mode;
        int  mode_left;
        bit  held;
        m_tready  = 1'b0;
        mode      = 0;
        mode_left = 0;
        held      = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request && !held)
            begin
                held = 1'b1;
                repeat (LONG_HOLD_CYCLES)
                begin
                    m_tready <= 1'b0;
                    @(negedge clk);
                end
            end
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 2);
                mode_left = $urandom_range(16, 200);
            end
            mode_left--;
            case (mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    function automatic logic [S_TDATA_W-1:0] pack_item(input logic [10:0] off,
                                                       input logic [7:0]  d,
                                                       input logic [3:0]  row,
                                                       input logic [10:0] caddr,
                                                       input logic        cur,
                                                       input logic [11:0] laddr);
        return {1'b0, laddr, cur, caddr, row, d, off};
    endfunction

    function automatic logic [S_TDATA_W-1:0] noise_payload();
        return pack_item(11'($urandom), 8'($urandom), 4'($urandom), 11'($urandom),
                         1'($urandom), 12'($urandom));
    endfunction

    function automatic logic [7:0] glyph_char();
        logic hi;
        hi = 1'($urandom);
        return {{6{hi}}, 2'($urandom)};
    endfunction

    task automatic send(input logic [CMD_W-1:0] cmd, input logic [S_TDATA_W-1:0] payload);
        if (gaps_on)
        begin
            if (burst_left == 0)
            begin
                repeat ($urandom_range(1, 8))
                begin
                    @(negedge clk);
                    s_tvalid <= 1'b0;
                end
                burst_left = $urandom_range(1, 24);
            end
            burst_left--;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= payload;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    initial
    begin : stimulus
        logic [CMD_W-1:0]     cmd;
        logic [S_TDATA_W-1:0] p;
        int                   pick;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        gaps_on      = 1'b0;
        hold_request = 1'b0;
        burst_left   = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // Only the lowest and highest ROM entries are loaded. Reads are kept inside them,
        // and video RAM only ever holds character codes whose glyph rows are loaded.
        for (int a = 0; a < ROM_EDGE_ENTRIES; a++)
        begin
            send(CMD_LOAD_CARD, pack_item(11'($urandom), 8'($urandom), 4'($urandom),
                                          11'($urandom), 1'($urandom), 12'(a)));
            send(CMD_LOAD_CARD, pack_item(11'($urandom), 8'($urandom), 4'($urandom),
                                          11'($urandom), 1'($urandom),
                                          12'(CARD_TOP_BASE + a)));
        end
        for (int a = 0; a < ROM_EDGE_ENTRIES; a++)
        begin
            send(CMD_LOAD_GLYPH, pack_item(11'($urandom), 8'($urandom), 4'($urandom),
                                           11'($urandom), 1'($urandom), 12'(a)));
            send(CMD_LOAD_GLYPH, pack_item(11'($urandom), 8'($urandom), 4'($urandom),
                                           11'($urandom), 1'($urandom),
                                           12'(GLYPH_TOP_BASE + a)));
        end

        gaps_on = 1'b1;
        send(CMD_IO_WRITE, pack_item(11'd0, 8'h00, 4'd0, 11'd0, 1'b0, 12'd0));
        send(CMD_IO_WRITE, pack_item(11'd1, 8'hFF, 4'd0, 11'd0, 1'b0, 12'd0));
        send(CMD_IO_READ, pack_item(11'd1, 8'h00, 4'd0, 11'd0, 1'b0, 12'd0));
        send(CMD_IO_WRITE, pack_item(11'h7FF, 8'hAA, 4'hF, 11'h7FF, 1'b1, 12'hFFF));
        send(CMD_WIN_WRITE, pack_item(11'h400, 8'hFC, 4'd0, 11'd0, 1'b0, 12'd0));
        send(CMD_WIN_WRITE, pack_item(11'h5FF, 8'hFF, 4'd0, 11'd0, 1'b0, 12'd0));
        send(CMD_WIN_WRITE, pack_item(11'h3FF, 8'h11, 4'd0, 11'd0, 1'b0, 12'd0));
        send(CMD_WIN_WRITE, pack_item(11'h600, 8'h22, 4'd0, 11'd0, 1'b0, 12'd0));
        send(CMD_WIN_WRITE, pack_item(11'h7FF, 8'h33, 4'd0, 11'd0, 1'b0, 12'd0));
        send(CMD_WIN_READ, pack_item(11'h400, 8'h00, 4'd0, 11'd0, 1'b0, 12'd0));
        send(CMD_WIN_READ, pack_item(11'h5FF, 8'h00, 4'd0, 11'd0, 1'b0, 12'd0));
        send(CMD_WIN_READ, pack_item(11'h3FF, 8'h00, 4'd0, 11'd0, 1'b0, 12'd0));
        send(CMD_WIN_READ, pack_item(11'h600, 8'h00, 4'd0, 11'd0, 1'b0, 12'd0));
        send(CMD_SLOT_READ, pack_item(11'h73F, 8'h00, 4'd0, 11'd0, 1'b0, 12'd0));
        send(CMD_SLOT_READ, pack_item(11'h000, 8'h00, 4'd0, 11'd0, 1'b0, 12'd0));
        send(CMD_IO_READ, pack_item(11'h004, 8'h00, 4'd0, 11'd0, 1'b0, 12'd0));
        send(CMD_WIN_READ, pack_item(11'h400, 8'h00, 4'd0, 11'd0, 1'b0, 12'd0));
        send(CMD_RENDER, pack_item(11'd0, 8'h00, 4'hF, 11'h7FF, 1'b1, 12'd0));
        send(CMD_RENDER, pack_item(11'd0, 8'h00, 4'h0, 11'h000, 1'b0, 12'd0));
        repeat (8) send(CMD_VSYNC, noise_payload());
        send(CMD_RENDER, pack_item(11'd0, 8'h00, 4'h3, 11'h600, 1'b1, 12'd0));
        send(CMD_LOAD_CARD, pack_item(11'd0, 8'h77, 4'd0, 11'd0, 1'b0, 12'd1024));
        send(CMD_LOAD_CARD, pack_item(11'd0, 8'h66, 4'd0, 11'd0, 1'b0, 12'hFFF));
        send(CMD_LOAD_GLYPH, pack_item(11'd0, 8'h0F, 4'd0, 11'd0, 1'b0, 12'hFFF));
        send(4'(LAST_CMD_CODE), noise_payload());

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            gaps_on = (i < 80 || i >= 160);
            if (i == 100)
                hold_request = 1'b1;
            p    = noise_payload();
            pick = $urandom_range(0, 99);
            if (pick < 10)
            begin
                cmd = CMD_IO_READ;
                if ($urandom_range(0, 3) != 0)
                    p[10:0] = 11'($urandom_range(0, 15));
            end
            else if (pick < 22)
            begin
                cmd = CMD_IO_WRITE;
                if ($urandom_range(0, 3) != 0)
                    p[10:0] = 11'($urandom_range(0, 15));
            end
            else if (pick < 30)
            begin
                cmd     = CMD_SLOT_READ;
                p[7:6]  = 2'b00;
            end
            else if (pick < 45)
            begin
                cmd     = CMD_WIN_READ;
                p[10:0] = 11'($urandom_range(CARD_TOP_BASE, 11'h7FF));
            end
            else if (pick < 60)
            begin
                cmd      = CMD_WIN_WRITE;
                p[18:11] = glyph_char();
                if ($urandom_range(0, 9) < 7)
                    p[10:0] = 11'($urandom_range(11'h3F0, 11'h61F));
            end
            else if (pick < 66)
                cmd = CMD_VSYNC;
            else if (pick < 84)
                cmd = CMD_RENDER;
            else if (pick < 89)
            begin
                cmd = CMD_LOAD_CARD;
                if ($urandom_range(0, 4) != 0)
                    p[46:35] = 12'($urandom_range(0, CARD_ROM_DEPTH_DFLT - 1));
            end
            else if (pick < 95)
                cmd = CMD_LOAD_GLYPH;
            else
                cmd = 4'($urandom_range(FIRST_UNUSED_CMD, LAST_CMD_CODE));
            send(cmd, p);
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (16) @(posedge clk);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
